// ===== design/fssd_pkg.sv =====
// Package: shared types and constants for the fair share slot dispatcher.
`default_nettype none
package fssd_pkg;
	localparam int MaxReq = 64;
	localparam int IdxW = $clog2(MaxReq);
	localparam int CntW = IdxW + 1;
	localparam logic ActLoad = 1'b0;
	localparam logic ActStart = 1'b1;

	typedef struct packed {
		logic        start;
		logic [15:0] id;
		logic [31:0] credit;
		logic [15:0] need;
		logic [15:0] free;
	} cmd_t;
endpackage
`default_nettype wire

// ===== design/fssd_front.sv =====
// Front end: accepts requests, computes need with a serial divider, queues commands.
`default_nettype none
module fssd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         action,
	input  wire logic [15:0]  requester_id,
	input  wire logic [31:0]  cell_credit,
	input  wire logic [15:0]  slot_cap,
	input  wire logic [15:0]  free_slots,
	input  wire logic [15:0]  cps,
	output logic              q_valid,
	input  wire logic         q_ready,
	output fssd_pkg::cmd_t    q_cmd
);
	import fssd_pkg::*;

	localparam logic [1:0] QDepth = 2'd2;

	logic        busy_q;
	logic [5:0]  bit_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [15:0] id_q;
	logic [31:0] credit_q;
	logic [15:0] cap_q;
	logic        done_q;

	cmd_t        fifo_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push;
	cmd_t        push_cmd;
	logic [32:0] trial;
	logic [15:0] need;
	logic [15:0] eff;

	// zero cells per slot counts as one
	assign eff = (cps == 16'd0) ? 16'd1 : cps;
	assign in_ready = !busy_q && !done_q && (cnt_q != QDepth);
	assign trial = {rem_q, dvd_q[31]} - {17'd0, eff};

	always_comb begin
		need = (quo_q > 32'd65535) ? 16'hFFFF : quo_q[15:0];
		if (need > cap_q) need = cap_q;
		push_cmd = '0;
		push = 1'b0;
		if (done_q) begin
			push = 1'b1;
			push_cmd.id = id_q;
			push_cmd.credit = credit_q;
			push_cmd.need = need;
		end else if (in_valid && in_ready && action == ActStart) begin
			push = 1'b1;
			push_cmd.start = 1'b1;
			push_cmd.free = free_slots;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q <= '0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && in_ready && action == ActLoad) begin
				busy_q <= 1'b1;
				bit_q <= 6'd32;
			end else if (busy_q) begin
				bit_q <= bit_q - 6'd1;
				if (bit_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (done_q) begin
				done_q <= 1'b0;
			end
			if (push) wp_q <= !wp_q;
			if (q_valid && q_ready) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_valid && q_ready};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && action == ActLoad) begin
			id_q <= requester_id;
			credit_q <= cell_credit;
			cap_q <= slot_cap;
			dvd_q <= cell_credit;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], dvd_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (push) fifo_q[wp_q] <= push_cmd;
	end

	assign q_valid = cnt_q != 2'd0;
	assign q_cmd = fifo_q[rp_q];

	ap_noover: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != QDepth || (q_valid && q_ready))) else $error("queue overflow");
	ap_divlen: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && bit_q == 6'd1) |=> done_q) else $error("divider did not finish");
	ap_noacc: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_ready) else $error("accept while dividing");
endmodule
`default_nettype wire

// ===== design/fssd_back.sv =====
// Back end: stores requesters, runs fair share passes and emits results.
`default_nettype none
module fssd_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_ready,
	input  fssd_pkg::cmd_t    q_cmd,
	input  wire logic [15:0]  cps,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [15:0]       granted_id,
	output logic [15:0]       slots_granted,
	output logic [31:0]       credit_left,
	output logic [15:0]       slots_unused,
	output logic              last
);
	import fssd_pkg::*;

	localparam logic [2:0] SIdle  = 3'd0;
	localparam logic [2:0] SCount = 3'd1;
	localparam logic [2:0] SDiv   = 3'd2;
	localparam logic [2:0] SPass  = 3'd3;
	localparam logic [2:0] SRd    = 3'd4;
	localparam logic [2:0] SMul   = 3'd5;
	localparam logic [2:0] SEmit  = 3'd6;

	logic [15:0] ids_m    [MaxReq];
	logic [31:0] credit_m [MaxReq];
	logic [15:0] need_m   [MaxReq];
	logic [15:0] gr_m     [MaxReq];

	logic [2:0]      st_q;
	logic [CntW-1:0] loaded_q;
	logic [CntW-1:0] open_q;
	logic [CntW-1:0] idx_q;
	logic [15:0]     rem_q;
	logic [15:0]     share_q;
	logic [15:0]     dq_q, dr_q;
	logic [4:0]      dbit_q;
	logic            rd_wait_q;
	logic [15:0]     need_rd_q, gr_rd_q, id_rd_q;
	logic [31:0]     credit_rd_q;
	logic [47:0]     used_q;

	logic [IdxW-1:0] idx;
	logic [16:0]     dtrial;
	logic [15:0]     g;
	logic [15:0]     eff;

	assign idx = idx_q[IdxW-1:0];
	assign eff = (cps == 16'd0) ? 16'd1 : cps;
	assign dtrial = {dr_q, rem_q[dbit_q[3:0]]} - {10'd0, open_q};
	assign q_ready = (st_q == SIdle);

	always_comb begin
		g = (need_rd_q < share_q) ? need_rd_q : share_q;
		if (g > rem_q) g = rem_q;
	end

	always_ff @(posedge clk) begin
		need_rd_q <= need_m[idx];
		gr_rd_q <= gr_m[idx];
		id_rd_q <= ids_m[idx];
		credit_rd_q <= credit_m[idx];
		if (st_q == SIdle && q_valid && !q_cmd.start && loaded_q != CntW'(MaxReq)) begin
			ids_m[loaded_q[IdxW-1:0]] <= q_cmd.id;
			credit_m[loaded_q[IdxW-1:0]] <= q_cmd.credit;
			need_m[loaded_q[IdxW-1:0]] <= q_cmd.need;
			gr_m[loaded_q[IdxW-1:0]] <= '0;
		end else if (st_q == SPass && !rd_wait_q && idx_q != loaded_q
				&& need_rd_q != 16'd0 && rem_q != 16'd0 && open_q != '0) begin
			need_m[idx] <= need_rd_q - g;
			gr_m[idx] <= gr_rd_q + g;
		end
		if (st_q == SMul) used_q <= 48'(gr_rd_q) * 48'(eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SIdle;
			loaded_q <= '0;
			open_q <= '0;
			idx_q <= '0;
			rem_q <= '0;
			rd_wait_q <= 1'b0;
			out_valid <= 1'b0;
			dbit_q <= '0;
		end else begin
			unique case (st_q)
				SIdle: if (q_valid) begin
					if (!q_cmd.start) begin
						if (loaded_q != CntW'(MaxReq)) loaded_q <= loaded_q + 1'b1;
					end else begin
						rem_q <= q_cmd.free;
						open_q <= '0;
						idx_q <= '0;
						rd_wait_q <= 1'b1;
						st_q <= SCount;
					end
				end
				SCount: begin
					if (rd_wait_q) rd_wait_q <= 1'b0;
					else if (idx_q == loaded_q) begin
						idx_q <= '0;
						st_q <= SDiv;
						dbit_q <= 5'd15;
						dq_q <= '0;
						dr_q <= '0;
					end else begin
						if (need_rd_q != 16'd0) open_q <= open_q + 1'b1;
						idx_q <= idx_q + 1'b1;
						rd_wait_q <= 1'b1;
					end
					if (!rd_wait_q && idx_q == loaded_q && loaded_q == '0) st_q <= SRd;
				end
				SDiv: begin
					if (open_q == '0 || rem_q == 16'd0) begin
						idx_q <= '0;
						rd_wait_q <= 1'b1;
						st_q <= SRd;
					end else begin
						if (!dtrial[16]) begin
							dr_q <= dtrial[15:0];
							dq_q <= {dq_q[14:0], 1'b1};
						end else begin
							dr_q <= {dr_q[14:0], rem_q[dbit_q[3:0]]};
							dq_q <= {dq_q[14:0], 1'b0};
						end
						if (dbit_q == 5'd0) begin
							share_q <= (dq_q[14:0] == 15'd0 && dtrial[16]) ? 16'd1
								: {dq_q[14:0], !dtrial[16]};
							idx_q <= '0;
							rd_wait_q <= 1'b1;
							st_q <= SPass;
						end
						dbit_q <= dbit_q - 5'd1;
					end
				end
				SPass: begin
					if (rd_wait_q) rd_wait_q <= 1'b0;
					else if (idx_q == loaded_q || rem_q == 16'd0 || open_q == '0) begin
						st_q <= SDiv;
						dbit_q <= 5'd15;
						dq_q <= '0;
						dr_q <= '0;
					end else begin
						if (need_rd_q != 16'd0) begin
							rem_q <= rem_q - g;
							if (need_rd_q == g) open_q <= open_q - 1'b1;
						end
						idx_q <= idx_q + 1'b1;
						rd_wait_q <= 1'b1;
					end
				end
				SRd: begin
					if (rd_wait_q) rd_wait_q <= 1'b0;
					else if (idx_q == loaded_q) begin
						loaded_q <= '0;
						open_q <= '0;
						st_q <= SIdle;
					end else st_q <= SMul;
				end
				SMul: st_q <= SEmit;
				SEmit: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						granted_id <= id_rd_q;
						slots_granted <= gr_rd_q;
						credit_left <= (used_q <= 48'(credit_rd_q))
							? credit_rd_q - used_q[31:0] : 32'd0;
						slots_unused <= rem_q;
						last <= (idx_q + 1'b1 == loaded_q);
					end else if (out_ready) begin
						out_valid <= 1'b0;
						idx_q <= idx_q + 1'b1;
						rd_wait_q <= 1'b1;
						st_q <= SRd;
					end
				end
				default: st_q <= SIdle;
			endcase
		end
	end

	ap_open: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= loaded_q) else $error("open count above loaded count");
	ap_load: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q <= CntW'(MaxReq)) else $error("load list overrun");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(granted_id))
		else $error("result dropped");
endmodule
`default_nettype wire

// ===== design/fair_share_slot_dispatch.sv =====
// Top level: fair share slot dispatcher.
// Load requests run a 32-step serial divider for the need, and the front end takes no
// new request while it divides. A start request counts open entries, then per pass runs
// a 16-step share divider and walks the loaded entries until slots or open entries run
// out; results then leave one by one. Front and back are split by a two-entry command queue.
`default_nettype none
module fair_share_slot_dispatch (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [79:0] s_axis_tdata,  // requester_id, cell_credit, slot_cap, free_slots
	input  wire logic        s_axis_tuser,  // action
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // granted_id, slots_granted, credit_left, slots_unused
	output logic             m_axis_tlast
);
	import fssd_pkg::*;

	logic [15:0] cps_q;
	logic        qv, qr;
	cmd_t        qc;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cps_q <= 16'd1;
		else if (cfg_valid) cps_q <= cfg_data;
	end

	fssd_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.action(s_axis_tuser),
		.requester_id(s_axis_tdata[15:0]), .cell_credit(s_axis_tdata[47:16]),
		.slot_cap(s_axis_tdata[63:48]), .free_slots(s_axis_tdata[79:64]),
		.cps(cps_q), .q_valid(qv), .q_ready(qr), .q_cmd(qc)
	);

	fssd_back u_back (
		.clk, .arst_n, .q_valid(qv), .q_ready(qr), .q_cmd(qc), .cps(cps_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.granted_id(m_axis_tdata[15:0]), .slots_granted(m_axis_tdata[31:16]),
		.credit_left(m_axis_tdata[63:32]), .slots_unused(m_axis_tdata[79:64]),
		.last(m_axis_tlast)
	);
endmodule
`default_nettype wire
